### sv/link_event_coalescer_unit_defines.svh
// Assertion macros for the link event coalescer RTL, used by its top level.
`ifndef LINK_EVENT_COALESCER_UNIT_DEFINES_SVH
`define LINK_EVENT_COALESCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lec_pkg.sv
// Types and constants shared by the link event coalescer modules.
package lec_pkg;

  // Port number width is fixed by the event format; every port number is in range.
  localparam int PORT_W      = 4;
  localparam int PORTS       = 1 << PORT_W;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int HOLD_W      = 16;
  localparam int TIME_W      = 32;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd250;

  // Input kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Bit positions inside a recorded port status
  localparam int ST_CARRIER = 0;
  localparam int ST_DORMANT = 1;
  localparam int ST_STACKED = 2;
  localparam int ST_DMODE   = 3;
  localparam int ST_ADMIN   = 4;

  // Operating states
  localparam logic [2:0] OPER_UNKNOWN    = 3'd0;
  localparam logic [2:0] OPER_DOWN       = 3'd1;
  localparam logic [2:0] OPER_LOWER_DOWN = 3'd2;
  localparam logic [2:0] OPER_DORMANT    = 3'd3;
  localparam logic [2:0] OPER_UP         = 3'd4;

  // Queueing actions
  localparam logic [1:0] ACT_NONE       = 2'd0;
  localparam logic [1:0] ACT_ACTIVATE   = 2'd1;
  localparam logic [1:0] ACT_DEACTIVATE = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] port;
    logic              carrier_ok;
    logic              dormant;
    logic              stacked;
    logic              dormant_mode;
    logic              admin_up;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic [2:0]        oper_state;
    logic              state_changed;
    logic [1:0]        action;
    logic              notify;
    logic              last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic event_take;
    logic tick_take;
    logic pop;
  } lec_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fire;
    logic has_items;
    logic last;
  } lec_sts_t;

endpackage

### sv/lec_ctrl.sv
// Controller: input/output handshakes and the drain sequencer.
module lec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lec_pkg::lec_sts_t   sts,
  output lec_pkg::lec_cmd_t   cmd
);

  localparam logic [0:0] S_IDLE  = 1'b0;
  localparam logic [0:0] S_DRAIN = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       out_valid_next;

  // Next state, commands and ready
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == lec_pkg::KIND_TICK) begin
            cmd.tick_take = 1'b1;
            if (sts.fire && sts.has_items) begin
              state_next = S_DRAIN;
            end
          end else begin
            cmd.event_take = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        // one queued port per cycle whenever the output register is free
        if (!out_valid || out_ready) begin
          cmd.pop        = 1'b1;
          out_valid_next = 1'b1;
          if (sts.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### sv/lec_datapath.sv
// Datapath: port tables, event FIFO, drain timer and result register.
module lec_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lec_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [lec_pkg::HOLD_W-1:0]          cfg_data,
  input  lec_pkg::lec_cmd_t                   cmd,
  output lec_pkg::lec_sts_t                   sts,
  output lec_pkg::out_item_t                  out_data
);

  logic [lec_pkg::HOLD_W-1:0] hold_ticks;
  logic [lec_pkg::PORTS-1:0]  pending_bits;
  logic [4:0]                 port_status [lec_pkg::PORTS];
  logic [2:0]                 port_oper   [lec_pkg::PORTS];
  logic [lec_pkg::PORT_W-1:0] event_fifo  [lec_pkg::QUEUE_DEPTH];
  logic [lec_pkg::IDX_W-1:0]  fifo_head;
  logic [lec_pkg::IDX_W-1:0]  fifo_tail;
  logic [lec_pkg::CNT_W-1:0]  fifo_count;
  logic                       drain_armed;
  logic [lec_pkg::TIME_W-1:0] now_ticks;
  logic [lec_pkg::TIME_W-1:0] next_allowed;
  logic [lec_pkg::TIME_W-1:0] drain_due;

  logic [lec_pkg::PORT_W-1:0] ev_port;
  logic [4:0]                 ev_status;
  logic                       fifo_full;
  logic                       enqueue;
  logic [lec_pkg::TIME_W-1:0] now_inc;
  logic [lec_pkg::TIME_W-1:0] tick_gap;
  logic [lec_pkg::TIME_W-1:0] wait_gap;
  logic                       delay_ok;
  logic                       fire;
  logic [lec_pkg::IDX_W-1:0]  head_inc;
  logic [lec_pkg::IDX_W-1:0]  tail_inc;
  logic [lec_pkg::PORT_W-1:0] dr_port;
  logic [4:0]                 dr_status;
  logic [2:0]                 dr_natural;
  logic [2:0]                 dr_old;
  logic                       dr_changed;
  logic [2:0]                 dr_oper;

  // RFC 2863 state from carrier, dormant and stacking
  function automatic logic [2:0] natural_state(input logic [4:0] st);
    logic [2:0] op;
    if (!st[lec_pkg::ST_CARRIER]) begin
      op = st[lec_pkg::ST_STACKED] ? lec_pkg::OPER_LOWER_DOWN : lec_pkg::OPER_DOWN;
    end else if (st[lec_pkg::ST_DORMANT]) begin
      op = lec_pkg::OPER_DORMANT;
    end else begin
      op = lec_pkg::OPER_UP;
    end
    return op;
  endfunction

  // Event side
  assign ev_port   = in_data.port;
  assign ev_status = {in_data.admin_up, in_data.dormant_mode, in_data.stacked,
                      in_data.dormant, in_data.carrier_ok};
  assign fifo_full = (fifo_count == lec_pkg::CNT_W'(lec_pkg::QUEUE_DEPTH));
  assign enqueue   = cmd.event_take && !pending_bits[ev_port] && !fifo_full;

  // Drain timing; wrapping 32-bit arithmetic
  assign now_inc  = now_ticks + lec_pkg::TIME_W'(1);
  assign tick_gap = now_inc - drain_due;
  assign fire     = drain_armed && !tick_gap[lec_pkg::TIME_W-1];
  assign wait_gap = next_allowed - now_ticks;
  assign delay_ok = (wait_gap <= lec_pkg::TIME_W'(hold_ticks));

  // FIFO pointers wrap at the queue depth
  assign head_inc = (fifo_head == lec_pkg::IDX_W'(lec_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : fifo_head + lec_pkg::IDX_W'(1);
  assign tail_inc = (fifo_tail == lec_pkg::IDX_W'(lec_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : fifo_tail + lec_pkg::IDX_W'(1);

  // Drain step for the port at the FIFO head
  assign dr_port    = event_fifo[fifo_head];
  assign dr_status  = port_status[dr_port];
  assign dr_natural = natural_state(dr_status);
  assign dr_old     = port_oper[dr_port];
  assign dr_changed = (dr_natural != dr_old);

  always_comb begin
    dr_oper = dr_old;
    if (dr_changed) begin
      // dormant mode promotes up to dormant
      if (dr_status[lec_pkg::ST_DMODE] && dr_natural == lec_pkg::OPER_UP) begin
        dr_oper = lec_pkg::OPER_DORMANT;
      end else begin
        dr_oper = dr_natural;
      end
    end
  end

  assign sts.fire      = fire;
  assign sts.has_items = (fifo_count != '0);
  assign sts.last      = (fifo_count == lec_pkg::CNT_W'(1));

  // Control state and port tables
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks   <= lec_pkg::HOLD_RESET;
      pending_bits <= '0;
      for (int i = 0; i < lec_pkg::PORTS; i++) begin
        port_status[i] <= '0;
        port_oper[i]   <= lec_pkg::OPER_UNKNOWN;
      end
      fifo_head    <= '0;
      fifo_tail    <= '0;
      fifo_count   <= '0;
      drain_armed  <= 1'b0;
      now_ticks    <= '0;
      next_allowed <= '0;
      drain_due    <= '0;
    end else begin
      if (cfg_we) begin
        hold_ticks <= cfg_data;
      end
      if (cmd.event_take) begin
        port_status[ev_port] <= ev_status;
      end
      if (enqueue) begin
        pending_bits[ev_port] <= 1'b1;
        fifo_tail             <= tail_inc;
        fifo_count            <= fifo_count + lec_pkg::CNT_W'(1);
        if (!drain_armed) begin
          drain_armed <= 1'b1;
          // delay above the hold period collapses to zero
          drain_due   <= delay_ok ? next_allowed : now_ticks;
        end
      end
      if (cmd.tick_take) begin
        now_ticks <= now_inc;
        if (fire) begin
          next_allowed <= now_inc + lec_pkg::TIME_W'(hold_ticks);
          drain_armed  <= 1'b0;
        end
      end
      if (cmd.pop) begin
        pending_bits[dr_port] <= 1'b0;
        if (dr_changed) begin
          port_oper[dr_port] <= dr_oper;
        end
        fifo_head  <= head_inc;
        fifo_count <= fifo_count - lec_pkg::CNT_W'(1);
      end
    end
  end

  // FIFO storage and result register
  always_ff @(posedge clk) begin
    if (enqueue) begin
      event_fifo[fifo_tail] <= ev_port;
    end
    if (cmd.pop) begin
      out_data.out_port      <= dr_port;
      out_data.oper_state    <= dr_oper;
      out_data.state_changed <= dr_changed;
      out_data.notify        <= dr_status[lec_pkg::ST_ADMIN];
      out_data.last          <= (fifo_count == lec_pkg::CNT_W'(1));
      if (dr_status[lec_pkg::ST_ADMIN]) begin
        out_data.action <= dr_status[lec_pkg::ST_CARRIER] ?
                           lec_pkg::ACT_ACTIVATE : lec_pkg::ACT_DEACTIVATE;
      end else begin
        out_data.action <= lec_pkg::ACT_NONE;
      end
    end
  end

endmodule

### sv/link_event_coalescer_unit.sv
// Top level of the link event coalescer: controller plus datapath.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_data   (lec_pkg::in_item_t)
//   out       output     out_valid / out_ready  out_data  (lec_pkg::out_item_t)
//   cfg       input      cfg_valid / cfg_ready  cfg_data  (hold_ticks, 16 bits)
//
// An event or a tick is taken while idle. A firing tick sends the queued ports
// through the result register, one port per cycle while the output is free, by the
// single drain sequencer; input is held off until the last port is out.
// A stalled output holds the drain; the final result may wait while input resumes.
// Reset is synchronous and clears all tables at once; cfg_ready is always high.
module link_event_coalescer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lec_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lec_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lec_pkg::HOLD_W-1:0]    cfg_data
);

  `include "link_event_coalescer_unit_defines.svh"

  lec_pkg::lec_cmd_t cmd;
  lec_pkg::lec_sts_t sts;

  assign cfg_ready = 1'b1;

  lec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lec_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // A drain step never overwrites a result that has not been taken
  `LEC_ASSERT_NOW(a_pop_slot_free, cmd.pop, (!out_valid || out_ready), "drain overwrote result")
  // Input is held off while the FIFO drains
  `LEC_ASSERT_NOW(a_no_input_in_drain, cmd.pop, !in_ready, "input open during drain")
  // The last drained port returns the block to taking input
  `LEC_ASSERT_NEXT(a_drain_ends, (cmd.pop && sts.last), in_ready, "drain did not end")
  // A firing tick with queued ports starts a drain
  `LEC_ASSERT_NEXT(a_tick_starts_drain,
    (cmd.tick_take && sts.fire && sts.has_items), !in_ready, "firing tick started no drain")

endmodule
